// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, ignored while reset is applied.
`define TAMVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define TAMVM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/tamvm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tamvm_pkg;

  // Commands carried by one input item.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;
  localparam logic [1:0] OP_STEP   = 2'd3;

  // Instruction set.
  localparam logic [3:0] OPC_ADD     = 4'd0;
  localparam logic [3:0] OPC_MUL     = 4'd1;
  localparam logic [3:0] OPC_SUB     = 4'd2;
  localparam logic [3:0] OPC_DIV     = 4'd3;
  localparam logic [3:0] OPC_COPY    = 4'd4;
  localparam logic [3:0] OPC_IMM     = 4'd5;
  localparam logic [3:0] OPC_JUMP    = 4'd6;
  localparam logic [3:0] OPC_JZ      = 4'd7;
  localparam logic [3:0] OPC_LESS    = 4'd8;
  localparam logic [3:0] OPC_GREATER = 4'd9;
  localparam logic [3:0] OPC_EQUAL   = 4'd10;
  localparam logic [3:0] OPC_PRINT   = 4'd11;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BAD_ADDR = 3'd2;
  localparam logic [2:0] ST_ABANDON  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;
  localparam logic [2:0] ST_HALTED   = 3'd5;
  localparam logic [2:0] ST_DIV_ZERO = 3'd6;

  typedef struct packed {
    logic capture;
    logic simple;
    logic lat_inst;
    logic lat_y;
    logic lat_z;
    logic lat_x;
    logic unit_start;
    logic commit;
    logic clr_en;
  } cmd_t;

  typedef struct packed {
    logic step_go;
    logic need_unit;
    logic unit_done;
    logic out_free;
    logic clr_last;
  } sts_t;

endpackage

`default_nettype wire

// File: sv/tamvm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tamvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/tamvm_iter.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tamvm_iter #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 is_div,
  input  wire logic [WORD_BITS-1:0] a,
  input  wire logic [WORD_BITS-1:0] b,
  output logic                      done,
  output logic      [WORD_BITS-1:0] result
);

  localparam int W    = WORD_BITS;
  localparam int CNTW = $clog2(WORD_BITS + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic          div_r, neg_r;
  logic [W-1:0]  acc_r, x_r, y_r;
  logic [W:0]    rem_sh, diff;

  assign rem_sh = {acc_r, x_r[W-1]};
  assign diff   = rem_sh - {1'b0, y_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CNTW'(W);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Multiply is shift-and-add; divide is restoring on the magnitudes.
  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= is_div;
      acc_r <= '0;
      neg_r <= a[W-1] ^ b[W-1];
      if (is_div) begin
        x_r <= a[W-1] ? -a : a;
        y_r <= b[W-1] ? -b : b;
      end else begin
        x_r <= a;
        y_r <= b;
      end
    end else if (busy_r) begin
      if (div_r) begin
        if (!diff[W]) begin
          acc_r <= diff[W-1:0];
          x_r   <= {x_r[W-2:0], 1'b1};
        end else begin
          acc_r <= rem_sh[W-1:0];
          x_r   <= {x_r[W-2:0], 1'b0};
        end
      end else begin
        if (y_r[0]) begin
          acc_r <= acc_r + x_r;
        end
        x_r <= {x_r[W-2:0], 1'b0};
        y_r <= {1'b0, y_r[W-1:1]};
      end
    end
  end

  assign done   = done_r;
  assign result = div_r ? (neg_r ? -x_r : x_r) : acc_r;

  `TAMVM_ASSERT(a_start_clears_done, start |=> !done_r, "unit done right after start")
  `TAMVM_ASSERT(a_done_not_busy, !(done_r && busy_r), "unit done while busy")

endmodule

`default_nettype wire

// File: sv/tamvm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tamvm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tamvm_pkg::sts_t sts,
  output tamvm_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SIMPLE = 4'd2;
  localparam logic [3:0] S_FETCH  = 4'd3;
  localparam logic [3:0] S_RDY    = 4'd4;
  localparam logic [3:0] S_RDZ    = 4'd5;
  localparam logic [3:0] S_RDX    = 4'd6;
  localparam logic [3:0] S_EXEC   = 4'd7;
  localparam logic [3:0] S_ITER   = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.step_go ? S_FETCH : S_SIMPLE;
        end
      end
      S_SIMPLE: begin
        if (sts.out_free) begin
          cmd.simple = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FETCH: begin
        cmd.lat_inst = 1'b1;
        state_nxt    = S_RDY;
      end
      S_RDY: begin
        cmd.lat_y = 1'b1;
        state_nxt = S_RDZ;
      end
      S_RDZ: begin
        cmd.lat_z = 1'b1;
        state_nxt = S_RDX;
      end
      S_RDX: begin
        cmd.lat_x = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.need_unit) begin
          cmd.unit_start = 1'b1;
          state_nxt      = S_ITER;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_ITER: begin
        if (sts.unit_done && sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TAMVM_ASSERT(a_result_slot_free, cmd.commit || cmd.simple |-> sts.out_free, "result lost")
  `TAMVM_ASSERT(a_commit_after_unit, cmd.commit && state_r == S_ITER |-> sts.unit_done, "early commit")

endmodule

`default_nettype wire

// File: sv/tamvm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tamvm_dp #(
  parameter int PROGRAM_DEPTH = 1024,
  parameter int DATA_DEPTH    = 256,
  parameter int WORD_BITS     = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tamvm_pkg::cmd_t cmd,
  output tamvm_pkg::sts_t      sts,
  input  wire logic [1:0]      in_op,
  input  wire logic [3:0]      in_opcode,
  input  wire logic [31:0]     in_first_arg,
  input  wire logic [31:0]     in_second_arg,
  input  wire logic [31:0]     in_third_arg,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [2:0]           out_status,
  output logic [9:0]           out_executed_ip,
  output logic [3:0]           out_executed_opcode,
  output logic [31:0]          out_shown_value,
  output logic                 out_shown_valid,
  output logic                 out_halted,
  output logic [10:0]          out_program_count
);

  localparam int W  = WORD_BITS;
  localparam int PW = $clog2(PROGRAM_DEPTH);
  localparam int CW = $clog2(PROGRAM_DEPTH + 1);
  localparam int AW = $clog2(DATA_DEPTH);
  localparam int IW = 4 + 3 * 32;

  function automatic logic addr_ok(input logic [31:0] a);
    addr_ok = !a[31] && (a < 32'(DATA_DEPTH));
  endfunction

  // Latched input item.
  logic [1:0]  op_r;
  logic [3:0]  opc_r;
  logic [31:0] a1_r, a2_r, a3_r;

  // Fetched instruction and its operands.
  logic [3:0]  iop_r;
  logic [31:0] ix_r, iy_r, iz_r;
  logic [W-1:0] vx_r, vy_r, vz_r;

  // Machine state.
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          lerr_r, lerr_nxt;
  logic          run_r, run_nxt;
  logic [AW-1:0] clr_cnt_r;

  // Result register.
  logic        out_valid_r;
  logic [2:0]  status_r, status_nxt;
  logic [9:0]  xip_r;
  logic [3:0]  xop_r;
  logic [31:0] shown_r;
  logic        sval_r;
  logic        halted_r;
  logic [10:0] pcount_r;

  logic [IW-1:0] prog_rdata;
  logic          prog_we;
  logic [W-1:0]  data_rdata, data_wdata, alu;
  logic [AW-1:0] data_raddr, data_waddr;
  logic          data_we, wr_op, append_ok, args_ok;
  logic [63:0]   imm64;
  logic [31:0]   jt;
  logic          do_jump, jump_ok, unit_done;
  logic [W-1:0]  unit_result;
  logic [CW-1:0] ip1;

  tamvm_ram #(.WIDTH(IW), .DEPTH(PROGRAM_DEPTH)) u_prog (
    .clk  (clk),
    .we   (prog_we),
    .waddr(count_r[PW-1:0]),
    .wdata({opc_r, a1_r, a2_r, a3_r}),
    .raddr(ptr_r[PW-1:0]),
    .rdata(prog_rdata)
  );

  tamvm_ram #(.WIDTH(W), .DEPTH(DATA_DEPTH)) u_data (
    .clk  (clk),
    .we   (data_we),
    .waddr(data_waddr),
    .wdata(data_wdata),
    .raddr(data_raddr),
    .rdata(data_rdata)
  );

  tamvm_iter #(.WORD_BITS(WORD_BITS)) u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.unit_start),
    .is_div(iop_r == tamvm_pkg::OPC_DIV),
    .a     (vy_r),
    .b     (vz_r),
    .done  (unit_done),
    .result(unit_result)
  );

  // Operands are read one per cycle: y, then z, then x.
  always_comb begin
    priority if (cmd.lat_inst) begin
      data_raddr = prog_rdata[32+AW-1:32];
    end else if (cmd.lat_y) begin
      data_raddr = iz_r[AW-1:0];
    end else begin
      data_raddr = ix_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      opc_r <= in_opcode;
      a1_r  <= in_first_arg;
      a2_r  <= in_second_arg;
      a3_r  <= in_third_arg;
    end
    if (cmd.lat_inst) begin
      iop_r <= prog_rdata[IW-1:96];
      ix_r  <= prog_rdata[95:64];
      iy_r  <= prog_rdata[63:32];
      iz_r  <= prog_rdata[31:0];
    end
    if (cmd.lat_y) begin
      vy_r <= data_rdata;
    end
    if (cmd.lat_z) begin
      vz_r <= data_rdata;
    end
    if (cmd.lat_x) begin
      vx_r <= data_rdata;
    end
  end

  assign imm64 = {{32{iy_r[31]}}, iy_r};

  always_comb begin
    alu = '0;
    unique case (iop_r)
      tamvm_pkg::OPC_ADD:     alu = vy_r + vz_r;
      tamvm_pkg::OPC_SUB:     alu = vy_r - vz_r;
      tamvm_pkg::OPC_COPY:    alu = vy_r;
      tamvm_pkg::OPC_IMM:     alu = imm64[W-1:0];
      tamvm_pkg::OPC_LESS:    alu = W'($signed(vy_r) < $signed(vz_r));
      tamvm_pkg::OPC_GREATER: alu = W'($signed(vz_r) < $signed(vy_r));
      tamvm_pkg::OPC_EQUAL:   alu = W'(vy_r == vz_r);
      default:                alu = '0;
    endcase
  end

  assign wr_op = (iop_r <= tamvm_pkg::OPC_EQUAL) && (iop_r != tamvm_pkg::OPC_JUMP) &&
                 (iop_r != tamvm_pkg::OPC_JZ);

  assign data_we    = cmd.clr_en || (cmd.commit && wr_op);
  assign data_waddr = cmd.clr_en ? clr_cnt_r : ix_r[AW-1:0];
  assign data_wdata = cmd.clr_en ? '0 :
                      ((iop_r == tamvm_pkg::OPC_MUL) ||
                       (iop_r == tamvm_pkg::OPC_DIV && vz_r != '0)) ? unit_result : alu;

  // Sequencing of the program counter after one step.
  assign ip1     = ptr_r + 1'b1;
  assign jt      = (iop_r == tamvm_pkg::OPC_JUMP) ? ix_r : iy_r;
  assign do_jump = (iop_r == tamvm_pkg::OPC_JUMP) || (iop_r == tamvm_pkg::OPC_JZ && vx_r == '0);
  assign jump_ok = !jt[31] && (jt < 32'(count_r));

  always_comb begin
    unique case (opc_r)
      tamvm_pkg::OPC_IMM, tamvm_pkg::OPC_JZ: args_ok = addr_ok(a1_r);
      tamvm_pkg::OPC_JUMP:                   args_ok = 1'b1;
      default: args_ok = addr_ok(a1_r) && addr_ok(a2_r) && addr_ok(a3_r);
    endcase
  end

  assign append_ok = (count_r < CW'(PROGRAM_DEPTH)) && args_ok;
  assign prog_we   = cmd.simple && (op_r == tamvm_pkg::OP_APPEND) && append_ok;

  always_comb begin
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    lerr_nxt   = lerr_r;
    run_nxt    = run_r;
    status_nxt = tamvm_pkg::ST_OK;
    if (cmd.simple) begin
      unique case (op_r)
        tamvm_pkg::OP_CLEAR: begin
          count_nxt = '0;
          ptr_nxt   = '0;
          lerr_nxt  = 1'b0;
          run_nxt   = 1'b0;
        end
        tamvm_pkg::OP_APPEND: begin
          if (count_r >= CW'(PROGRAM_DEPTH)) begin
            lerr_nxt   = 1'b1;
            status_nxt = tamvm_pkg::ST_FULL;
          end else if (!args_ok) begin
            lerr_nxt   = 1'b1;
            status_nxt = tamvm_pkg::ST_BAD_ADDR;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        tamvm_pkg::OP_START: begin
          if (lerr_r) begin
            status_nxt = tamvm_pkg::ST_ABANDON;
            run_nxt    = 1'b0;
          end else begin
            ptr_nxt = '0;
            run_nxt = count_r != '0;
          end
        end
        default: begin
          run_nxt    = 1'b0;
          status_nxt = tamvm_pkg::ST_HALTED;
        end
      endcase
    end else if (cmd.commit) begin
      if (do_jump && jump_ok) begin
        ptr_nxt = jt[CW-1:0];
      end else begin
        ptr_nxt = ip1;
      end
      run_nxt = !(do_jump && !jump_ok) && (ptr_nxt < count_r);
      if (iop_r == tamvm_pkg::OPC_DIV && vz_r == '0) begin
        status_nxt = tamvm_pkg::ST_DIV_ZERO;
      end else if (iop_r > tamvm_pkg::OPC_PRINT) begin
        status_nxt = tamvm_pkg::ST_UNKNOWN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      lerr_r      <= 1'b0;
      run_r       <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      lerr_r  <= lerr_nxt;
      run_r   <= run_nxt;
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.simple || cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.simple || cmd.commit) begin
      status_r <= status_nxt;
      xip_r    <= cmd.commit ? 10'(ptr_r) : '0;
      xop_r    <= cmd.commit ? iop_r : '0;
      sval_r   <= cmd.commit && (iop_r == tamvm_pkg::OPC_PRINT);
      shown_r  <= (cmd.commit && iop_r == tamvm_pkg::OPC_PRINT) ? 32'(vx_r) : '0;
      halted_r <= !run_nxt;
      pcount_r <= 11'(count_nxt);
    end
  end

  assign sts.step_go   = (in_op == tamvm_pkg::OP_STEP) && run_r && (ptr_r < count_r);
  assign sts.need_unit = (iop_r == tamvm_pkg::OPC_MUL) ||
                         (iop_r == tamvm_pkg::OPC_DIV && vz_r != '0);
  assign sts.unit_done = unit_done;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign sts.clr_last  = clr_cnt_r == AW'(DATA_DEPTH - 1);

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_executed_ip     = xip_r;
  assign out_executed_opcode = xop_r;
  assign out_shown_value     = shown_r;
  assign out_shown_valid     = sval_r;
  assign out_halted          = halted_r;
  assign out_program_count   = pcount_r;

  `TAMVM_ASSERT(a_run_in_program, run_r |-> ptr_r < count_r, "running past program end")
  `TAMVM_ASSERT(a_count_bound, count_r <= CW'(PROGRAM_DEPTH), "program count overflow")

endmodule

`default_nettype wire

// File: sv/three_address_memory_vm.sv
// Three-address machine: items clear the program, append an instruction, start a run, or
// execute one instruction; each item gives exactly one result. After reset the data
// memory is zeroed by a clearing pass over every word, during which no item is taken.
// Clear, append, start and a step with no active run pass from the input transfer
// through the simple state into the result register. A step goes through program fetch,
// three data operand reads through the single data memory read port, then execute and
// write-back. Multiply and a divide by a nonzero value run through a shared
// one-bit-per-cycle unit. One item is worked on at a time; the result register lets the
// next item be taken while the last result waits.
`timescale 1ns / 1ps
`default_nettype none

module three_address_memory_vm #(
  parameter int PROGRAM_DEPTH = 1024,
  parameter int DATA_DEPTH    = 256,
  parameter int WORD_BITS     = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic        [1:0]  in_op,
  input  wire logic        [3:0]  in_opcode,
  input  wire logic signed [31:0] in_first_arg,
  input  wire logic signed [31:0] in_second_arg,
  input  wire logic signed [31:0] in_third_arg,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic             [2:0]  out_status,
  output logic             [9:0]  out_executed_ip,
  output logic             [3:0]  out_executed_opcode,
  output logic signed      [31:0] out_shown_value,
  output logic                    out_shown_valid,
  output logic                    out_halted,
  output logic             [10:0] out_program_count
);

  tamvm_pkg::cmd_t cmd;
  tamvm_pkg::sts_t sts;

  tamvm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  tamvm_dp #(
    .PROGRAM_DEPTH(PROGRAM_DEPTH),
    .DATA_DEPTH   (DATA_DEPTH),
    .WORD_BITS    (WORD_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_op              (in_op),
    .in_opcode          (in_opcode),
    .in_first_arg       (in_first_arg),
    .in_second_arg      (in_second_arg),
    .in_third_arg       (in_third_arg),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_executed_ip    (out_executed_ip),
    .out_executed_opcode(out_executed_opcode),
    .out_shown_value    (out_shown_value),
    .out_shown_valid    (out_shown_valid),
    .out_halted         (out_halted),
    .out_program_count  (out_program_count)
  );

endmodule

`default_nettype wire
